@@ rtl/wbss_pkg.sv @@
// ----------------------------------------------------------------------------
// wbss_pkg
// Shared types and constants for the wildcard byte signature scanner.
// ----------------------------------------------------------------------------
package wbss_pkg;

  // Longest signature the window can hold.
  localparam int MAX_PATTERN = 16;
  // Width of the saturating byte counter within a region.
  localparam int COUNT_WIDTH = 32;
  // Number of pattern bytes and care bits that the registers carry.
  localparam int PATTERN_BYTES = 16;
  // Width of the pattern length register.
  localparam int PLEN_W = 5;
  // Width of a clamped length; wide enough for both MAX_PATTERN and the register.
  localparam int LEN_W = ($clog2(MAX_PATTERN + 1) > PLEN_W) ?
                         $clog2(MAX_PATTERN + 1) : PLEN_W;
  // Width of an index into the window.
  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  // Result queue between the front and back parts.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // Register file layout: 64-bit registers at byte address 8*i.
  localparam int DATA_W = 64;
  localparam int ADDR_W = 6;
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_LOW  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_HIGH = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CARE_MASK    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_LEN  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_REGION_BASE  = 3'd4;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic [63:0]              pattern_low_bytes;
    logic [63:0]              pattern_high_bytes;
    logic [PATTERN_BYTES-1:0] care_mask;
    logic [PLEN_W-1:0]        pattern_length;
    logic [63:0]              region_base;
  } cfg_t;

  // One classified result waiting for address formation.
  typedef struct packed {
    logic                   found;
    logic [COUNT_WIDTH-1:0] offset;
  } q_entry_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

@@ rtl/wildcard_byte_signature_scan_core.sv @@
// ----------------------------------------------------------------------------
// wildcard_byte_signature_scan_core
// Scans a byte stream for the first match of a wildcard byte signature.
// ----------------------------------------------------------------------------
// Usage:
//   Program the signature, care mask, length and region base over the APB
//   port while the block is idle. Then stream the region one byte per beat on
//   the input channel (in_valid/in_stall), marking the final byte with
//   last_byte. Each region yields at most one beat on the output channel
//   (out_valid/out_stall): found with the address of the first match, or
//   not-found (address zero) on the last byte if nothing matched.
//   Throughput is one byte per cycle while in_stall is low: the window shift
//   and the parallel masked compare of all positions sit in the input stage.
//   A result is queued when the byte that caused it is accepted, and then
//   loads the output register, where the address add is, once that register
//   is free.
//   A stalled output beat holds; the input keeps flowing until the four-entry
//   result queue fills, and only then is in_stall raised.
//   Reset clears the registers, the window readable flags, the byte counter,
//   the match flag, the queue and the output valid.
// ----------------------------------------------------------------------------
module wildcard_byte_signature_scan_core (
  input  logic                         clk,
  input  logic                         rst,
  // Configuration port.
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [wbss_pkg::ADDR_W-1:0]  paddr,
  input  logic [wbss_pkg::DATA_W-1:0]  pwdata,
  output logic [wbss_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  // Input channel.
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   data_byte,
  input  logic                         readable,
  input  logic                         last_byte,
  // Output channel.
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         found,
  output logic [63:0]                  match_address
);

  wbss_pkg::cfg_t      cfg;
  wbss_pkg::q_entry_t  push_entry;
  wbss_pkg::q_entry_t  head;
  wbss_pkg::q_status_t status;
  logic                accept;
  logic                push;
  logic                pop;

  // Input beats are taken while the result queue has room.
  assign in_stall = status.full;
  assign accept   = in_valid && !in_stall;

  wbss_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  wbss_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept    (accept),
    .data_byte (data_byte),
    .readable  (readable),
    .last_byte (last_byte),
    .push      (push),
    .entry     (push_entry)
  );

  wbss_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (status)
  );

  wbss_back u_back (
    .clk           (clk),
    .rst           (rst),
    .region_base   (cfg.region_base),
    .head          (head),
    .status        (status),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .found         (found),
    .match_address (match_address)
  );

endmodule

@@ rtl/wbss_regs.sv @@
// ----------------------------------------------------------------------------
// wbss_regs
// APB register file holding the signature, care mask, length and region base.
// ----------------------------------------------------------------------------
module wbss_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [wbss_pkg::ADDR_W-1:0]  paddr,
  input  logic [wbss_pkg::DATA_W-1:0]  pwdata,
  output logic [wbss_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output wbss_pkg::cfg_t               cfg
);

  logic                                 wr_en;
  logic [wbss_pkg::REG_IDX_W-1:0]       reg_idx;

  // The register index is the 8-byte word address.
  assign reg_idx = paddr[wbss_pkg::ADDR_W-1:3];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;

  // Register writes during the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        wbss_pkg::REG_PATTERN_LOW:  cfg.pattern_low_bytes  <= pwdata;
        wbss_pkg::REG_PATTERN_HIGH: cfg.pattern_high_bytes <= pwdata;
        wbss_pkg::REG_CARE_MASK:
          cfg.care_mask <= pwdata[wbss_pkg::PATTERN_BYTES-1:0];
        wbss_pkg::REG_PATTERN_LEN:
          cfg.pattern_length <= pwdata[wbss_pkg::PLEN_W-1:0];
        wbss_pkg::REG_REGION_BASE:  cfg.region_base        <= pwdata;
        default: ;
      endcase
    end
  end

  // Read data mux.
  always_comb begin
    unique case (reg_idx)
      wbss_pkg::REG_PATTERN_LOW:  prdata = cfg.pattern_low_bytes;
      wbss_pkg::REG_PATTERN_HIGH: prdata = cfg.pattern_high_bytes;
      wbss_pkg::REG_CARE_MASK:
        prdata = wbss_pkg::DATA_W'(cfg.care_mask);
      wbss_pkg::REG_PATTERN_LEN:
        prdata = wbss_pkg::DATA_W'(cfg.pattern_length);
      wbss_pkg::REG_REGION_BASE:  prdata = cfg.region_base;
      default:                    prdata = '0;
    endcase
  end

endmodule

@@ rtl/wbss_front.sv @@
// ----------------------------------------------------------------------------
// wbss_front
// Accepts bytes, shifts the window and judges the window that ends on each
// byte, emitting a found or not-found entry when one is due.
// ----------------------------------------------------------------------------
module wbss_front (
  input  logic               clk,
  input  logic               rst,
  input  wbss_pkg::cfg_t     cfg,
  input  logic               accept,
  input  logic [7:0]         data_byte,
  input  logic               readable,
  input  logic               last_byte,
  output logic               push,
  output wbss_pkg::q_entry_t entry
);

  localparam int MP   = wbss_pkg::MAX_PATTERN;
  localparam int CW   = wbss_pkg::COUNT_WIDTH;
  localparam int LW   = wbss_pkg::LEN_W;
  localparam int IW   = wbss_pkg::IDX_W;

  logic [7:0]    win_bytes [MP];
  logic [MP-1:0] win_rd;
  logic [CW-1:0] byte_count;
  logic          match_seen;

  logic [7:0]    win_bytes_next [MP];
  logic [MP-1:0] win_rd_next;
  logic [LW-1:0] len;
  logic [LW-1:0] len_m1;
  logic [MP-1:0] pos_ok;
  logic          window_ok;
  logic          hit;
  logic [CW-1:0] offset;

  // Window after this byte: entry 0 is the newest byte.
  always_comb begin
    win_bytes_next[0] = data_byte;
    win_rd_next[0]    = readable;
    for (int k = 1; k < MP; k++) begin
      win_bytes_next[k] = win_bytes[k-1];
      win_rd_next[k]    = win_rd[k-1];
    end
  end

  // Clamp the length to the window size.
  assign len = (LW'(cfg.pattern_length) > LW'(MP)) ? LW'(MP) : LW'(cfg.pattern_length);
  assign len_m1 = len - LW'(1);

  // Per pattern position check; position i sits at window entry len-1-i.
  for (genvar g = 0; g < MP; g++) begin : g_pos
    logic [7:0]    pat;
    logic          cared;
    logic [LW-1:0] ent;

    if (g < 8) begin : g_low
      assign pat   = cfg.pattern_low_bytes[8*g +: 8];
      assign cared = cfg.care_mask[g];
    end else if (g < wbss_pkg::PATTERN_BYTES) begin : g_high
      assign pat   = cfg.pattern_high_bytes[8*(g-8) +: 8];
      assign cared = cfg.care_mask[g];
    end else begin : g_none
      assign pat   = 8'h00;
      assign cared = 1'b0;
    end

    assign ent = len_m1 - LW'(g);
    assign pos_ok[g] = (LW'(g) >= len) || !cared ||
                       (win_rd_next[ent[IW-1:0]] && (win_bytes_next[ent[IW-1:0]] == pat));
  end

  // Full window judgment, start offset and the entry to queue.
  always_comb begin
    window_ok = (byte_count >= CW'(len_m1)) && win_rd_next[len_m1[IW-1:0]] && (&pos_ok);
    if (len == '0) begin
      hit    = !match_seen && readable;
      offset = byte_count;
    end else begin
      hit    = !match_seen && window_ok;
      offset = byte_count - CW'(len_m1);
    end
    push         = accept && (hit || (last_byte && !match_seen));
    entry.found  = hit;
    entry.offset = hit ? offset : '0;
  end

  // Window bytes carry no reset; unreadable entries are never compared.
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int k = 0; k < MP; k++) begin
        win_bytes[k] <= win_bytes_next[k];
      end
    end
  end

  // Readable flags, byte counter and match flag; a last byte re-arms the scan.
  always_ff @(posedge clk) begin
    if (rst) begin
      win_rd     <= '0;
      byte_count <= '0;
      match_seen <= 1'b0;
    end else if (accept) begin
      if (last_byte) begin
        win_rd     <= '0;
        byte_count <= '0;
        match_seen <= 1'b0;
      end else begin
        win_rd <= win_rd_next;
        if (byte_count != '1) begin
          byte_count <= byte_count + CW'(1);
        end
        if (hit) begin
          match_seen <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/wbss_queue.sv @@
// ----------------------------------------------------------------------------
// wbss_queue
// Short FIFO of classified results between the front and back parts.
// ----------------------------------------------------------------------------
module wbss_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  wbss_pkg::q_entry_t  push_entry,
  input  logic                pop,
  output wbss_pkg::q_entry_t  head,
  output wbss_pkg::q_status_t status
);

  localparam int PW = wbss_pkg::QPTR_W;
  localparam int CNW = wbss_pkg::QCNT_W;

  wbss_pkg::q_entry_t slots [wbss_pkg::QUEUE_DEPTH];
  logic [PW-1:0]      wr_ptr;
  logic [PW-1:0]      rd_ptr;
  logic [CNW-1:0]     count;
  logic [CNW-1:0]     count_next;

  assign head         = slots[rd_ptr];
  assign status.full  = (count == CNW'(wbss_pkg::QUEUE_DEPTH));
  assign status.empty = (count == '0);

  // Occupancy follows pushes and pops in the same cycle.
  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + CNW'(1);
    end else if (pop && !push) begin
      count_next = count - CNW'(1);
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Pointers and count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
    end
  end

endmodule

@@ rtl/wbss_back.sv @@
// ----------------------------------------------------------------------------
// wbss_back
// Takes queued results, forms the match address and holds it in the output
// register until the receiver takes the beat.
// ----------------------------------------------------------------------------
module wbss_back (
  input  logic                clk,
  input  logic                rst,
  input  logic [63:0]         region_base,
  input  wbss_pkg::q_entry_t  head,
  input  wbss_pkg::q_status_t status,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                found,
  output logic [63:0]         match_address
);

  logic load_ok;

  // The output register can load when empty or when its beat leaves now.
  assign load_ok = !out_valid || !out_stall;
  assign pop     = load_ok && !status.empty;

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_ok) begin
      out_valid <= !status.empty;
    end
  end

  // Output payload: base plus offset for a match, zero for not found.
  always_ff @(posedge clk) begin
    if (pop) begin
      found         <= head.found;
      match_address <= head.found ? (region_base + 64'(head.offset)) : 64'd0;
    end
  end

endmodule

@@ rtl/wbss_checker.sv @@
// ----------------------------------------------------------------------------
// wbss_checker
// Port-level checks on the output channel of the signature scanner.
// ----------------------------------------------------------------------------
module wbss_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic        found,
  input logic [63:0] match_address
);

  // Reset empties the output register.
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // A not-found beat carries a zero address.
  a_notfound_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (match_address == 64'd0))
    else $error("not-found beat with nonzero address");

  // A stalled beat stays valid.
  a_stall_valid: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled beat dropped");

  // A stalled beat keeps its payload.
  a_stall_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> ($stable(found) && $stable(match_address)))
    else $error("stalled payload changed");

endmodule

bind wildcard_byte_signature_scan_core wbss_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .found         (found),
  .match_address (match_address)
);

@@ tb/wbss_scan_checker.sv @@
// ----------------------------------------------------------------------------
// wbss_scan_checker
// Watches the register port and both beat channels of the signature scanner,
// keeps its own copy of the registers and of the scan window, predicts the
// result of every accepted byte and compares each output beat against it.
// ----------------------------------------------------------------------------
module wbss_scan_checker
  import wbss_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic              pready,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [7:0]        data_byte,
  input  logic              readable,
  input  logic              last_byte,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic              found,
  input  logic [63:0]       match_address,
  output int                fail_count,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        found;
    logic [63:0] address;
  } scan_result_t;

  // Register copy.
  logic [63:0]              sig_lo;
  logic [63:0]              sig_hi;
  logic [PATTERN_BYTES-1:0] sig_care;
  logic [PLEN_W-1:0]        sig_len;
  logic [63:0]              base_addr;

  // Scan state: entry k holds the byte k beats before the newest one.
  logic [7:0]             win_byte [MAX_PATTERN];
  logic                   win_rd   [MAX_PATTERN];
  logic [COUNT_WIDTH-1:0] scan_count;
  logic                   hit_reported;

  scan_result_t expected_results[$];
  int           errors = 0;

  function automatic logic [7:0] sig_byte(int i);
    if (i < 8) return sig_lo[8*i +: 8];
    if (i < 16) return sig_hi[8*(i-8) +: 8];
    return 8'h00;
  endfunction

  // Shift one byte into the window and judge the window that it completes.
  task automatic predict_byte(input logic [7:0] b, input logic rd, input logic last);
    int                     span;
    int                     e;
    logic                   hit;
    logic [COUNT_WIDTH-1:0] off;
    for (int k = MAX_PATTERN - 1; k > 0; k--) begin
      win_byte[k] = win_byte[k-1];
      win_rd[k]   = win_rd[k-1];
    end
    win_byte[0] = b;
    win_rd[0]   = rd;

    span = (int'(sig_len) > MAX_PATTERN) ? MAX_PATTERN : int'(sig_len);
    hit  = 1'b0;
    off  = '0;
    if (!hit_reported) begin
      if (span == 0) begin
        // An empty signature matches at the first readable byte.
        hit = rd;
        off = scan_count;
      end else if (scan_count >= COUNT_WIDTH'(span - 1) && win_rd[span-1]) begin
        hit = 1'b1;
        for (int i = 0; i < span; i++) begin
          e = span - 1 - i;
          if (i < PATTERN_BYTES && sig_care[i] &&
              (!win_rd[e] || win_byte[e] != sig_byte(i)))
            hit = 1'b0;
        end
        off = scan_count - COUNT_WIDTH'(span - 1);
      end
    end

    if (hit) begin
      expected_results.push_back('{found: 1'b1, address: base_addr + 64'(off)});
      hit_reported = 1'b1;
    end else if (last && !hit_reported) begin
      expected_results.push_back('{found: 1'b0, address: 64'h0});
    end

    if (scan_count != '1) scan_count++;

    // The end of a region re-arms the scan.
    if (last) begin
      scan_count   = '0;
      hit_reported = 1'b0;
      for (int k = 0; k < MAX_PATTERN; k++) win_rd[k] = 1'b0;
    end
  endtask

  task automatic check_result();
    scan_result_t want;
    if (expected_results.size() == 0) begin
      errors++;
      if (errors <= 20)
        $display("%0t: unexpected result beat: found=%0b address=%h",
                 $realtime, found, match_address);
    end else begin
      want = expected_results.pop_front();
      if (found !== want.found) begin
        errors++;
        if (errors <= 20)
          $display("%0t: found mismatch: expected %0b, actual %0b",
                   $realtime, want.found, found);
      end
      if (match_address !== want.address) begin
        errors++;
        if (errors <= 20)
          $display("%0t: match_address mismatch: expected %h, actual %h",
                   $realtime, want.address, match_address);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      sig_lo       = '0;
      sig_hi       = '0;
      sig_care     = '0;
      sig_len      = '0;
      base_addr    = '0;
      scan_count   = '0;
      hit_reported = 1'b0;
      for (int k = 0; k < MAX_PATTERN; k++) begin
        win_byte[k] = 8'h00;
        win_rd[k]   = 1'b0;
      end
      expected_results.delete();
      pending <= 0;
    end else begin
      // Register writes.
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:3])
          REG_PATTERN_LOW:  sig_lo    = pwdata;
          REG_PATTERN_HIGH: sig_hi    = pwdata;
          REG_CARE_MASK:    sig_care  = pwdata[PATTERN_BYTES-1:0];
          REG_PATTERN_LEN:  sig_len   = pwdata[PLEN_W-1:0];
          REG_REGION_BASE:  base_addr = pwdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_byte(data_byte, readable, last_byte);
      if (out_valid && !out_stall) check_result();
      pending <= expected_results.size();
    end
    fail_count <= errors;
  end

endmodule

@@ tb/tb_wildcard_byte_signature_scan_core.sv @@
// ----------------------------------------------------------------------------
// tb_wildcard_byte_signature_scan_core
// Drives the signature scanner with a directed set of regions and then with
// random regions, most of which carry a planted copy of the signature, under
// several register settings. Input bursts and output stalls are random. The
// checker beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_wildcard_byte_signature_scan_core;
  timeunit 1ns;
  timeprecision 1ps;
  import wbss_pkg::*;

  localparam int IDLE_LIMIT  = 5000;
  localparam int PHASE_BYTES = 70;
  localparam int RAND_PHASES = 8;

  typedef enum int {STALL_NONE, STALL_HALF, STALL_HEAVY, STALL_PERIODIC} stall_mode_e;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [7:0]        data_byte = 8'h00;
  logic              readable = 1'b0;
  logic              last_byte = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              found;
  logic [63:0]       match_address;

  int scan_fail_count;
  int scan_pending;

  // Signature as currently programmed, used to plant matches.
  logic [7:0]  cur_sig [PATTERN_BYTES];
  logic [15:0] cur_care = '0;
  int          cur_len = 0;
  int          burst_left = 0;
  int          phase_bytes = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  wildcard_byte_signature_scan_core dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .data_byte(data_byte), .readable(readable), .last_byte(last_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .found(found), .match_address(match_address)
  );

  wbss_scan_checker checker_i (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .data_byte(data_byte), .readable(readable), .last_byte(last_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .found(found), .match_address(match_address),
    .fail_count(scan_fail_count), .pending(scan_pending)
  );

  // Receiver stalls, switching between stall patterns at random.
  stall_mode_e stall_mode = STALL_NONE;
  int          mode_left = 0;
  int          stall_tick = 0;

  always @(negedge clk) begin
    if (mode_left == 0) begin
      mode_left  = $urandom_range(20, 120);
      stall_mode = stall_mode_e'($urandom_range(0, 3));
    end
    mode_left--;
    stall_tick++;
    case (stall_mode)
      STALL_NONE:     out_stall <= 1'b0;
      STALL_HALF:     out_stall <= ($urandom_range(0, 1) == 1);
      STALL_HEAVY:    out_stall <= ($urandom_range(0, 9) < 8);
      STALL_PERIODIC: out_stall <= (stall_tick % 3 != 0);
      default:        out_stall <= 1'b0;
    endcase
  end

  // Watchdog on cycles with no beat and no register write.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // One register write: setup phase, then access phase until pready.
  task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [63:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(input logic [63:0] lo, input logic [63:0] hi,
                            input logic [15:0] care, input logic [4:0] len,
                            input logic [63:0] base);
    reg_write(REG_PATTERN_LOW, lo);
    reg_write(REG_PATTERN_HIGH, hi);
    reg_write(REG_CARE_MASK, {48'h0, care});
    reg_write(REG_PATTERN_LEN, {59'h0, len});
    reg_write(REG_REGION_BASE, base);
    for (int i = 0; i < 8; i++) begin
      cur_sig[i]   = lo[8*i +: 8];
      cur_sig[i+8] = hi[8*i +: 8];
    end
    cur_care = care;
    cur_len  = int'(len);
  endtask

  // Send one byte beat; called and returning just after a falling edge.
  task automatic send_byte(input logic [7:0] b, input logic rd, input logic last);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
    end
    burst_left--;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    readable  <= rd;
    last_byte <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // One region: either noise, or a region with the signature planted in it.
  task automatic send_region(input bit plant);
    int         n;
    int         at;
    int         span;
    logic [7:0] b;
    logic       rd;
    span = (cur_len > MAX_PATTERN) ? MAX_PATTERN : cur_len;
    n    = plant ? span + $urandom_range(0, 20) : $urandom_range(1, 12);
    if (n == 0) n = 1;
    at = $urandom_range(0, n - span);
    for (int i = 0; i < n; i++) begin
      b  = 8'($urandom_range(0, 255));
      rd = plant ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 1) == 1);
      if (plant && i >= at && i < at + span) begin
        if (cur_care[i-at]) b = cur_sig[i-at];
        rd = ($urandom_range(0, 24) != 0);
      end
      send_byte(b, rd, i == n - 1);
      phase_bytes++;
    end
  endtask

  // Wait until every predicted result has come out and the pipeline is empty.
  task automatic settle();
    in_valid <= 1'b0;
    while (scan_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    logic [15:0] care;
    logic [4:0]  len;
    logic [63:0] base;
    for (int i = 0; i < PATTERN_BYTES; i++) cur_sig[i] = 8'h00;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: empty signature, so the first readable byte matches.
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b1, 1'b1);
    send_byte(8'hFF, 1'b0, 1'b1);
    settle();

    // Three bytes, middle one a wildcard, base near the top of the address space.
    set_config(64'h0000_0000_005A_FF00, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0005, 5'd3,
               64'hFFFF_FFFF_FFFF_FFFE);
    send_byte(8'h11, 1'b1, 1'b0);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'h33, 1'b1, 1'b0);
    send_byte(8'h5A, 1'b1, 1'b1);
    // Unreadable cared byte, then a window starting on an unreadable byte.
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'h77, 1'b1, 1'b0);
    send_byte(8'h5A, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b1, 1'b0);
    send_byte(8'h5A, 1'b1, 1'b1);
    // A match that would run past the region end.
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b1, 1'b1);
    settle();

    // First position a wildcard: an unreadable start byte still blocks it.
    set_config(64'h0000_0000_0000_FF00, 64'h0, 16'h0002, 5'd3, 64'h0);
    send_byte(8'h12, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b1, 1'b0);
    send_byte(8'h34, 1'b1, 1'b0);
    send_byte(8'h56, 1'b1, 1'b1);
    send_byte(8'h12, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b1, 1'b0);
    send_byte(8'h34, 1'b1, 1'b1);
    settle();

    // Random phases, each under its own settings.
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p % 4)
        0:       care = 16'hFFFF;
        1:       care = 16'($urandom);
        2:       care = 16'h0000;
        default: care = 16'($urandom) & 16'($urandom);
      endcase
      case (p)
        0:       len = 5'd16;
        1:       len = 5'd1;
        2:       len = 5'd31;
        3:       len = 5'd0;
        4:       len = 5'd17;
        5:       len = 5'($urandom_range(2, 16));
        6:       len = 5'd8;
        default: len = 5'($urandom_range(0, 31));
      endcase
      case (p)
        0:       base = 64'hFFFF_FFFF_FFFF_FFFF;
        1:       base = 64'h0;
        default: base = {$urandom, $urandom};
      endcase
      set_config({$urandom, $urandom}, {$urandom, $urandom}, care, len, base);
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) send_region($urandom_range(0, 9) < 7);
      settle();
    end

    if (scan_fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ wildcard_byte_signature_scan_core.f @@
rtl/wbss_pkg.sv
rtl/wbss_regs.sv
rtl/wbss_front.sv
rtl/wbss_queue.sv
rtl/wbss_back.sv
rtl/wildcard_byte_signature_scan_core.sv
rtl/wbss_checker.sv
tb/wbss_scan_checker.sv
tb/tb_wildcard_byte_signature_scan_core.sv
